@@ rtl/telemetry_frame_builder_crc16_macros.svh @@
// Assertion macros shared by the telemetry frame builder checkers.
`ifndef TELEMETRY_FRAME_BUILDER_CRC16_MACROS_SVH
`define TELEMETRY_FRAME_BUILDER_CRC16_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TFB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is high.
`define TFB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication that also holds across reset.
`define TFB_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

@@ rtl/tfb_pkg.sv @@
// Types, constants and helper functions of the telemetry frame builder.
package tfb_pkg;

   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_SEND_PERIOD = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_VOLTAGE_MAX = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CURRENT_MAX = 2'd2;

   localparam logic [15:0] SEND_PERIOD_RESET = 16'd200;
   localparam logic [14:0] VOLTAGE_MAX_RESET = 15'd6000;
   localparam logic [14:0] CURRENT_MAX_RESET = 15'd15000;

   localparam logic [7:0] SYNC_BYTE_0 = 8'hAA;
   localparam logic [7:0] SYNC_BYTE_1 = 8'h55;
   localparam logic [7:0] LENGTH_BYTE = 8'd17;

   localparam logic [7:0] FLAG_INACTIVE  = 8'h01;
   localparam logic [7:0] FLAG_COMM_LOST = 8'h02;
   localparam logic [7:0] FLAG_ENGINE_ON = 8'h04;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic signed [9:0] TEMP_MIN = -10'sd40;
   localparam logic signed [9:0] TEMP_MAX = 10'sd150;

   localparam int NUM_WORDS = 7;

   // Byte positions inside one frame.
   localparam logic [4:0] POS_SEQ       = 5'd3;
   localparam logic [4:0] POS_FLAGS     = 5'd4;
   localparam logic [4:0] POS_FAULT     = 5'd5;
   localparam logic [4:0] POS_WORDS     = 5'd6;
   localparam logic [4:0] POS_LAST_WORD = 5'd19;
   localparam logic [4:0] POS_CRC_LO    = 5'd20;
   localparam logic [4:0] POS_CRC_HI    = 5'd21;

   typedef struct packed {
      logic [31:0]        now_ms;
      logic               system_active;
      logic               comm_lost;
      logic               engine_running;
      logic [7:0]         fault_code;
      logic signed [15:0] voltage_centi;
      logic signed [15:0] current_m1_centi;
      logic signed [15:0] current_m2_centi;
      logic signed [15:0] current_m3_centi;
      logic signed [15:0] current_m4_centi;
      logic signed [9:0]  temp_left_deg;
      logic signed [9:0]  temp_right_deg;
   } sample_type;

   // One frame's variable content; words go out in index order, high byte first.
   typedef struct packed {
      logic [7:0]                     seq;
      logic [7:0]                     flags;
      logic [7:0]                     fault;
      logic [NUM_WORDS-1:0][15:0]     words;
   } frame_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [15:0] clamp_positive(input logic signed [15:0] v,
                                                  input logic [14:0] max_val);
      logic [15:0] r;
      if (v[15]) begin
         r = 16'd0;
      end else if (v[14:0] > max_val) begin
         r = {1'b0, max_val};
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [15:0] clamp_temp(input logic signed [9:0] v);
      logic signed [9:0] c;
      if (v < TEMP_MIN) begin
         c = TEMP_MIN;
      end else if (v > TEMP_MAX) begin
         c = TEMP_MAX;
      end else begin
         c = v;
      end
      return {{6{c[9]}}, c};
   endfunction

   // One byte of CRC-16/MODBUS, reflected, bit at a time.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

@@ rtl/tfb_front.sv @@
// Front end: timing gate, sequence numbering, clamping and frame record build.
module tfb_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  tfb_pkg::sample_type  sample,
   input  logic [15:0]          send_period,
   input  logic [14:0]          voltage_max,
   input  logic [14:0]          current_max,
   output logic                 push,
   output tfb_pkg::frame_type   push_frame
);

   logic [31:0] last_send_ff, last_send_in;
   logic [7:0]  seq_ff, seq_in;
   logic [31:0] elapsed;
   logic        due;

   // Unsigned difference wraps modulo 2^32.
   assign elapsed = sample.now_ms - last_send_ff;
   assign due     = elapsed >= {16'd0, send_period};
   assign push    = accept && due;

   always_comb begin
      last_send_in = last_send_ff;
      seq_in       = seq_ff;
      if (push) begin
         last_send_in = sample.now_ms;
         seq_in       = seq_ff + 8'd1;
      end
   end

   always_comb begin
      push_frame.seq   = seq_ff;
      push_frame.flags = (sample.system_active ? 8'd0 : tfb_pkg::FLAG_INACTIVE)
                       | (sample.comm_lost ? tfb_pkg::FLAG_COMM_LOST : 8'd0)
                       | (sample.engine_running ? tfb_pkg::FLAG_ENGINE_ON : 8'd0);
      push_frame.fault = sample.fault_code;
      push_frame.words[0] = tfb_pkg::clamp_positive(sample.voltage_centi, voltage_max);
      push_frame.words[1] = tfb_pkg::clamp_positive(sample.current_m1_centi, current_max);
      push_frame.words[2] = tfb_pkg::clamp_positive(sample.current_m2_centi, current_max);
      push_frame.words[3] = tfb_pkg::clamp_positive(sample.current_m3_centi, current_max);
      push_frame.words[4] = tfb_pkg::clamp_positive(sample.current_m4_centi, current_max);
      push_frame.words[5] = tfb_pkg::clamp_temp(sample.temp_left_deg);
      push_frame.words[6] = tfb_pkg::clamp_temp(sample.temp_right_deg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_send_ff <= 32'd0;
         seq_ff       <= 8'd0;
      end else begin
         last_send_ff <= last_send_in;
         seq_ff       <= seq_in;
      end
   end

endmodule

@@ rtl/tfb_queue.sv @@
// Small first-in first-out queue of frame records between front and back.
module tfb_queue #(
   parameter int DEPTH = tfb_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  tfb_pkg::frame_type            push_frame,
   input  logic                          pop,
   output tfb_pkg::frame_type            head,
   output tfb_pkg::queue_status_type     status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   tfb_pkg::frame_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign head         = entries_ff[rd_ptr_ff];
   assign status.full  = count_ff == FULL_CNT;
   assign status.empty = count_ff == '0;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/tfb_back.sv @@
// Back end: serializes one frame record into bytes and runs the CRC.
module tfb_back (
   input  logic                       clock,
   input  logic                       reset,
   input  tfb_pkg::frame_type         head,
   input  tfb_pkg::queue_status_type  q_status,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,
   output logic                       rsp_tlast
);

   tfb_pkg::frame_type frame_ff, frame_in;
   logic        busy_ff, busy_in;
   logic [4:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_last_ff, out_last_in;
   logic        slot_free;
   logic        start;
   logic        step;
   logic [7:0]  cur_byte;
   logic [4:0]  word_off;
   logic [15:0] cur_word;

   assign slot_free = !out_valid_ff || rsp_tready;
   assign start     = slot_free && !busy_ff && !q_status.empty;
   assign step      = slot_free && busy_ff;
   assign pop       = start;

   assign word_off = pos_ff - tfb_pkg::POS_WORDS;
   assign cur_word = frame_ff.words[word_off[3:1]];

   always_comb begin
      case (pos_ff)
         5'd1:                 cur_byte = tfb_pkg::SYNC_BYTE_1;
         5'd2:                 cur_byte = tfb_pkg::LENGTH_BYTE;
         tfb_pkg::POS_SEQ:     cur_byte = frame_ff.seq;
         tfb_pkg::POS_FLAGS:   cur_byte = frame_ff.flags;
         tfb_pkg::POS_FAULT:   cur_byte = frame_ff.fault;
         tfb_pkg::POS_CRC_LO:  cur_byte = crc_ff[7:0];
         tfb_pkg::POS_CRC_HI:  cur_byte = crc_ff[15:8];
         default:              cur_byte = word_off[0] ? cur_word[7:0] : cur_word[15:8];
      endcase
   end

   always_comb begin
      frame_in     = frame_ff;
      busy_in      = busy_ff;
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (slot_free) begin
         out_valid_in = 1'b0;
      end
      if (start) begin
         // The first sync byte is registered as the record is taken and goes out in the cycle after.
         frame_in     = head;
         busy_in      = 1'b1;
         pos_in       = 5'd1;
         crc_in       = tfb_pkg::CRC_INIT;
         out_valid_in = 1'b1;
         out_byte_in  = tfb_pkg::SYNC_BYTE_0;
         out_last_in  = 1'b0;
      end else if (step) begin
         out_valid_in = 1'b1;
         out_byte_in  = cur_byte;
         out_last_in  = pos_ff == tfb_pkg::POS_CRC_HI;
         if (pos_ff inside {[tfb_pkg::POS_SEQ : tfb_pkg::POS_LAST_WORD]}) begin
            crc_in = tfb_pkg::crc_feed(crc_ff, cur_byte);
         end
         if (pos_ff == tfb_pkg::POS_CRC_HI) begin
            busy_in = 1'b0;
            pos_in  = 5'd0;
         end else begin
            pos_in = pos_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      frame_ff    <= frame_in;
      crc_ff      <= crc_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pos_ff       <= 5'd0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

@@ rtl/telemetry_frame_builder_crc16.sv @@
// Top level of the telemetry frame builder with CRC-16/MODBUS trailer.
//
//   Channel  Direction  Moves                          Handshake
//   req_*    in         one time sample per request    tvalid/tready
//   rsp_*    out        one frame byte per request     tvalid/tready, tlast on CRC high byte
//   csr_*    in         register write                 csr_we, no wait
//
// Every request is taken while the frame queue has room; a sample that
// is not yet due is dropped there and produces nothing. A due sample yields a
// 22-byte frame sent one byte per cycle on the byte-wide output while rsp_tready
// holds high. Reset is synchronous and active high; it restores the register
// defaults and clears the send time, sequence number, queue and serializer.
// A stall on rsp holds the output byte; once the queue is full, req_tready drops.
module telemetry_frame_builder_crc16 #(
   parameter int QUEUE_DEPTH = tfb_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata, lowest bit up: now_ms[31:0], system_active, comm_lost,
   // engine_running, fault_code[7:0], voltage_centi[15:0], current_m1_centi[15:0],
   // current_m2_centi[15:0], current_m3_centi[15:0], current_m4_centi[15:0],
   // temp_left_deg[9:0], temp_right_deg[9:0], one zero pad bit
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tfb_pkg::REQ_DATA_W-1:0]  req_tdata,
   // rsp_tdata, lowest bit up: frame_byte[7:0]; rsp_tlast carries last_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tfb_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [tfb_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [tfb_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic [15:0] send_period_ff;
   logic [14:0] voltage_max_ff;
   logic [14:0] current_max_ff;

   tfb_pkg::sample_type        sample;
   tfb_pkg::frame_type         push_frame;
   tfb_pkg::frame_type         head;
   tfb_pkg::queue_status_type  q_status;
   logic                       req_accept;
   logic                       push;
   logic                       pop;

   // Configuration registers; writes to an unused index fall through the case.
   always_ff @(posedge clock) begin
      if (reset) begin
         send_period_ff <= tfb_pkg::SEND_PERIOD_RESET;
         voltage_max_ff <= tfb_pkg::VOLTAGE_MAX_RESET;
         current_max_ff <= tfb_pkg::CURRENT_MAX_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            tfb_pkg::CSR_SEND_PERIOD: send_period_ff <= csr_wdata;
            tfb_pkg::CSR_VOLTAGE_MAX: voltage_max_ff <= csr_wdata[14:0];
            tfb_pkg::CSR_CURRENT_MAX: current_max_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // Unpack the request fields.
   assign sample.now_ms           = req_tdata[31:0];
   assign sample.system_active    = req_tdata[32];
   assign sample.comm_lost        = req_tdata[33];
   assign sample.engine_running   = req_tdata[34];
   assign sample.fault_code       = req_tdata[42:35];
   assign sample.voltage_centi    = req_tdata[58:43];
   assign sample.current_m1_centi = req_tdata[74:59];
   assign sample.current_m2_centi = req_tdata[90:75];
   assign sample.current_m3_centi = req_tdata[106:91];
   assign sample.current_m4_centi = req_tdata[122:107];
   assign sample.temp_left_deg    = req_tdata[132:123];
   assign sample.temp_right_deg   = req_tdata[142:133];

   // The front end never needs to wait on anything but a full queue.
   assign req_tready = !q_status.full;
   assign req_accept = req_tvalid && req_tready;

   tfb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .sample      (sample),
      .send_period (send_period_ff),
      .voltage_max (voltage_max_ff),
      .current_max (current_max_ff),
      .push        (push),
      .push_frame  (push_frame)
   );

   tfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   tfb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ rtl/tfb_checker.sv @@
// Port-level checker for the telemetry frame builder, bound to the top level.
`include "telemetry_frame_builder_crc16_macros.svh"

module tfb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tfb_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tlast
);

   logic rsp_accept;
   assign rsp_accept = rsp_tvalid && rsp_tready;

   // A stalled byte stays put.
   `TFB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // The byte after a frame's last byte is the first sync byte of the next frame.
   `TFB_ASSERT_NEXT(a_frame_restart, clock, reset, rsp_accept && rsp_tlast, !rsp_tvalid || rsp_tdata == tfb_pkg::SYNC_BYTE_0)

   // The output was already valid before any byte marked as the end of a frame.
   `TFB_ASSERT_SAME(a_sync_not_last, clock, reset, rsp_tvalid && rsp_tlast, $past(rsp_tvalid))

   // Reset leaves the output empty and the input open.
   `TFB_ASSERT_NEXT_ALWAYS(a_reset_state, clock, reset, !rsp_tvalid && req_tready)

endmodule

bind telemetry_frame_builder_crc16 tfb_checker u_tfb_checker (.*);
